[src/sscc_pkg.sv]
// shared types, constants and digit helpers for the seven-segment clock controller
package sscc_pkg;

   // word kinds on the request channel
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_KEY  = 1'b1
   } op_type;

   // key codes carried by a key press word
   typedef enum logic [1:0] {
      KEY_HOUR_UP   = 2'd0,
      KEY_MINUTE_UP = 2'd1,
      KEY_SECOND_UP = 2'd2,
      KEY_MODE      = 2'd3
   } key_type;

   // configuration register indexes
   localparam logic [2:0] CSR_ALARM_HOUR       = 3'd0;
   localparam logic [2:0] CSR_ALARM_MINUTE     = 3'd1;
   localparam logic [2:0] CSR_TICKS_PER_SECOND = 3'd2;
   localparam logic [2:0] CSR_BLINK_TICK       = 3'd3;
   localparam logic [2:0] CSR_BANNER_DIGITS    = 3'd4;

   // configuration reset values
   localparam logic [4:0]  ALARM_HOUR_RST       = 5'd14;
   localparam logic [5:0]  ALARM_MINUTE_RST     = 6'd1;
   localparam logic [7:0]  TICKS_PER_SECOND_RST = 8'd14;
   localparam logic [7:0]  BLINK_TICK_RST       = 8'd7;
   localparam logic [15:0] BANNER_DIGITS_RST    = 16'h2019;

   // wrap limits
   localparam logic [5:0] PHASE_STEPS     = 6'd18;
   localparam logic [5:0] SECONDS_WRAP    = 6'd60;
   localparam logic [5:0] MINUTES_WRAP    = 6'd60;
   localparam logic [5:0] HOURS_WRAP      = 6'd24;

   // display phase boundaries in cycling mode
   localparam logic [4:0] PHASE_LAST_MMSS = 5'd9;
   localparam logic [4:0] PHASE_LAST_HHMM = 5'd14;

   localparam logic [7:0] POINT_BIT = 8'h80;

   // time state after one word, as seen by the display decoder
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [7:0] tick_count;
      logic [4:0] phase;
      logic       cycle_mode;
      logic       beep;
      logic       alarm;
   } time_view_type;

   // step up by one, back to zero when the limit is reached
   function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
      logic [6:0] inc;
      inc = {1'b0, v} + 7'd1;
      wrap_up = (inc >= {1'b0, limit}) ? 6'd0 : inc[5:0];
   endfunction

   // tens digit of a value below 64
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      priority if (v >= 6'd60) tens_of = 4'd6;
      else if (v >= 6'd50) tens_of = 4'd5;
      else if (v >= 6'd40) tens_of = 4'd4;
      else if (v >= 6'd30) tens_of = 4'd3;
      else if (v >= 6'd20) tens_of = 4'd2;
      else if (v >= 6'd10) tens_of = 4'd1;
      else tens_of = 4'd0;
   endfunction

   // units digit of a value below 64
   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [5:0] t;
      logic [5:0] r;
      t = {2'b00, tens_of(v)};
      r = v - 6'((t << 3) + (t << 1));
      ones_of = r[3:0];
   endfunction

   // segment pattern of one decimal digit, blank above nine
   function automatic logic [7:0] seg_of(input logic [3:0] d);
      unique case (d)
         4'd0:    seg_of = 8'h3f;
         4'd1:    seg_of = 8'h06;
         4'd2:    seg_of = 8'h5b;
         4'd3:    seg_of = 8'h4f;
         4'd4:    seg_of = 8'h66;
         4'd5:    seg_of = 8'h6d;
         4'd6:    seg_of = 8'h7d;
         4'd7:    seg_of = 8'h07;
         4'd8:    seg_of = 8'h7f;
         4'd9:    seg_of = 8'h6f;
         default: seg_of = 8'h00;
      endcase
   endfunction

endpackage

[src/sscc_timekeeper.sv]
// time of day, tick count, display phase and mode registers with their update
module sscc_timekeeper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  operation,
   input  logic [1:0]            key,
   input  logic [4:0]            alarm_hour,
   input  logic [5:0]            alarm_minute,
   input  logic [7:0]            ticks_per_second,
   output sscc_pkg::time_view_type view
);

   logic [7:0] tick_ff, tick_in;
   logic [4:0] phase_ff, phase_in;
   logic [4:0] hour_ff, hour_in;
   logic [5:0] min_ff, min_in;
   logic [5:0] sec_ff, sec_in;
   logic       mode_ff, mode_in;
   logic [7:0] tick_inc;
   logic       beep;
   logic       alarm;

   assign tick_inc = tick_ff + 8'd1;

   // next state for one word
   always_comb begin
      tick_in  = tick_ff;
      phase_in = phase_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      mode_in  = mode_ff;
      beep     = 1'b0;
      alarm    = 1'b0;
      if (operation == sscc_pkg::OP_TICK) begin
         tick_in = tick_inc;
         if (tick_inc >= ticks_per_second) begin
            // a second passes, carry through minutes and hours
            tick_in  = 8'd0;
            phase_in = 5'(sscc_pkg::wrap_up({1'b0, phase_ff}, sscc_pkg::PHASE_STEPS));
            sec_in   = sscc_pkg::wrap_up(sec_ff, sscc_pkg::SECONDS_WRAP);
            if (sec_in == 6'd0) begin
               min_in = sscc_pkg::wrap_up(min_ff, sscc_pkg::MINUTES_WRAP);
               if (min_in == 6'd0) begin
                  hour_in = 5'(sscc_pkg::wrap_up({1'b0, hour_ff}, sscc_pkg::HOURS_WRAP));
               end
            end
            alarm = (hour_in == alarm_hour) && (min_in == alarm_minute) && (sec_in == 6'd0);
         end
      end else begin
         beep = 1'b1;
         unique case (key)
            sscc_pkg::KEY_HOUR_UP: begin
               hour_in = 5'(sscc_pkg::wrap_up({1'b0, hour_ff}, sscc_pkg::HOURS_WRAP));
            end
            sscc_pkg::KEY_MINUTE_UP: begin
               min_in = sscc_pkg::wrap_up(min_ff, sscc_pkg::MINUTES_WRAP);
            end
            sscc_pkg::KEY_SECOND_UP: begin
               sec_in = sscc_pkg::wrap_up(sec_ff, sscc_pkg::SECONDS_WRAP);
            end
            sscc_pkg::KEY_MODE: begin
               mode_in = ~mode_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= 8'd0;
         phase_ff <= 5'd0;
         hour_ff  <= 5'd0;
         min_ff   <= 6'd0;
         sec_ff   <= 6'd0;
         mode_ff  <= 1'b0;
      end else if (step_en) begin
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         mode_ff  <= mode_in;
      end
   end

   // updated state towards the display decoder
   always_comb begin
      view.hours      = hour_in;
      view.minutes    = min_in;
      view.seconds    = sec_in;
      view.tick_count = tick_in;
      view.phase      = phase_in;
      view.cycle_mode = mode_in;
      view.beep       = beep;
      view.alarm      = alarm;
   end

endmodule

[src/sscc_seg_decode.sv]
// selects the display view and turns its digits into segment patterns
module sscc_seg_decode (
   input  sscc_pkg::time_view_type view,
   input  logic [7:0]              blink_tick,
   input  logic [15:0]             banner_digits,
   output logic [7:0]              seg0,
   output logic [7:0]              seg1,
   output logic [7:0]              seg2,
   output logic [7:0]              seg3
);

   logic show_mmss;
   logic show_hhmm;

   assign show_mmss = !view.cycle_mode || (view.phase <= sscc_pkg::PHASE_LAST_MMSS);
   assign show_hhmm = view.phase <= sscc_pkg::PHASE_LAST_HHMM;

   // mm.ss, hh mm or banner
   always_comb begin
      priority if (show_mmss) begin
         seg0 = sscc_pkg::seg_of(sscc_pkg::tens_of(view.minutes));
         seg1 = sscc_pkg::seg_of(sscc_pkg::ones_of(view.minutes));
         if (view.tick_count < blink_tick) begin
            seg1 = seg1 | sscc_pkg::POINT_BIT;
         end
         seg2 = sscc_pkg::seg_of(sscc_pkg::tens_of(view.seconds));
         seg3 = sscc_pkg::seg_of(sscc_pkg::ones_of(view.seconds));
      end else if (show_hhmm) begin
         seg0 = sscc_pkg::seg_of(sscc_pkg::tens_of({1'b0, view.hours}));
         seg1 = sscc_pkg::seg_of(sscc_pkg::ones_of({1'b0, view.hours}));
         seg2 = sscc_pkg::seg_of(sscc_pkg::tens_of(view.minutes));
         seg3 = sscc_pkg::seg_of(sscc_pkg::ones_of(view.minutes));
      end else begin
         seg0 = sscc_pkg::seg_of(banner_digits[15:12]);
         seg1 = sscc_pkg::seg_of(banner_digits[11:8]);
         seg2 = sscc_pkg::seg_of(banner_digits[7:4]);
         seg3 = sscc_pkg::seg_of(banner_digits[3:0]);
      end
   end

endmodule

[src/seven_segment_clock_controller.sv]
// top level of the seven-segment clock controller: registers, handshakes and result stage
// Every request word (a timer overflow tick or a key press) yields one response word
// with the four segment patterns after the update, a beep flag and an alarm flag.
// A word is taken into an input register, then the time update and display decode
// run combinationally into the response register, which presents the response; a word
// moves on only while the response register is empty or drained by rsp_ready, and one
// word per cycle is sustained while rsp_ready stays high. Configuration writes are
// always taken and registered; indexes above four are ignored.
module seven_segment_clock_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [1:0]  req_key,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_seg_digit0,
   output logic [7:0]  rsp_seg_digit1,
   output logic [7:0]  rsp_seg_digit2,
   output logic [7:0]  rsp_seg_digit3,
   output logic        rsp_beep_pulse,
   output logic        rsp_alarm_start,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [4:0]  alarm_hour_ff;
   logic [5:0]  alarm_minute_ff;
   logic [7:0]  tps_ff;
   logic [7:0]  blink_tick_ff;
   logic [15:0] banner_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_op_ff;
   logic [1:0]  s1_key_ff;
   logic        s2_load;
   logic        req_accept;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  seg0_ff, seg1_ff, seg2_ff, seg3_ff;
   logic        beep_ff, alarm_ff;
   logic [7:0]  seg0, seg1, seg2, seg3;

   sscc_pkg::time_view_type view;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hour_ff   <= sscc_pkg::ALARM_HOUR_RST;
         alarm_minute_ff <= sscc_pkg::ALARM_MINUTE_RST;
         tps_ff          <= sscc_pkg::TICKS_PER_SECOND_RST;
         blink_tick_ff   <= sscc_pkg::BLINK_TICK_RST;
         banner_ff       <= sscc_pkg::BANNER_DIGITS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            sscc_pkg::CSR_ALARM_HOUR:       alarm_hour_ff   <= csr_wdata[4:0];
            sscc_pkg::CSR_ALARM_MINUTE:     alarm_minute_ff <= csr_wdata[5:0];
            sscc_pkg::CSR_TICKS_PER_SECOND: tps_ff          <= csr_wdata[7:0];
            sscc_pkg::CSR_BLINK_TICK:       blink_tick_ff   <= csr_wdata[7:0];
            sscc_pkg::CSR_BANNER_DIGITS:    banner_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // handshake control
   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s2_load;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      priority if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      priority if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff  <= req_operation;
         s1_key_ff <= req_key;
      end
   end

   // time update
   sscc_timekeeper u_timekeeper (
      .clock            (clock),
      .reset            (reset),
      .step_en          (s2_load),
      .operation        (s1_op_ff),
      .key              (s1_key_ff),
      .alarm_hour       (alarm_hour_ff),
      .alarm_minute     (alarm_minute_ff),
      .ticks_per_second (tps_ff),
      .view             (view)
   );

   // display decode
   sscc_seg_decode u_seg_decode (
      .view          (view),
      .blink_tick    (blink_tick_ff),
      .banner_digits (banner_ff),
      .seg0          (seg0),
      .seg1          (seg1),
      .seg2          (seg2),
      .seg3          (seg3)
   );

   // response register
   always_ff @(posedge clock) begin
      if (s2_load) begin
         seg0_ff  <= seg0;
         seg1_ff  <= seg1;
         seg2_ff  <= seg2;
         seg3_ff  <= seg3;
         beep_ff  <= view.beep;
         alarm_ff <= view.alarm;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seg_digit0  = seg0_ff;
   assign rsp_seg_digit1  = seg1_ff;
   assign rsp_seg_digit2  = seg2_ff;
   assign rsp_seg_digit3  = seg3_ff;
   assign rsp_beep_pulse  = beep_ff;
   assign rsp_alarm_start = alarm_ff;

`ifndef SYNTHESIS
   // a word leaving the input register always shows up as a response
   a_load_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid)
      else $error("response missing after load");

   // a key word beeps and never raises the alarm
   a_key_beeps: assert property (@(posedge clock) disable iff (reset)
      (s2_load && (s1_op_ff == sscc_pkg::OP_KEY)) |=> (rsp_beep_pulse && !rsp_alarm_start))
      else $error("key word response wrong");

   // a tick word never beeps
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (s2_load && (s1_op_ff == sscc_pkg::OP_TICK)) |=> !rsp_beep_pulse)
      else $error("tick word beeped");

   // a new word enters a full input register only while it drains
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_valid_ff) |-> s2_load)
      else $error("input register overwritten");
`endif

endmodule

[bench/tb_seven_segment_clock_controller.sv]
// self-checking testbench of the seven-segment clock controller with its own clock and display predictor
`timescale 1ns / 100ps

module tb_seven_segment_clock_controller;

   localparam int CLOCK_PERIOD  = 10;
   localparam int STALL_CYCLES  = 200;
   localparam int SETTLE_CYCLES = 10;
   localparam int TIMEOUT_NS    = 3_000_000;

   // segment patterns of the digits nine down to zero, zero in the low byte
   localparam logic [79:0] DIGIT_GLYPHS = 80'h6f_7f_07_7d_6d_66_4f_5b_06_3f;

   // one result word as the display shows it
   typedef struct packed {
      logic [7:0] digit0;
      logic [7:0] digit1;
      logic [7:0] digit2;
      logic [7:0] digit3;
      logic       beep;
      logic       alarm;
   } panel_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [1:0]  req_key = 2'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_seg_digit0;
   logic [7:0]  rsp_seg_digit1;
   logic [7:0]  rsp_seg_digit2;
   logic [7:0]  rsp_seg_digit3;
   logic        rsp_beep_pulse;
   logic        rsp_alarm_start;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'd0;

   // predicted time of day, display phase and settings
   logic [7:0]  clk_ticks;
   logic [4:0]  clk_phase;
   logic [4:0]  clk_hours;
   logic [5:0]  clk_minutes;
   logic [5:0]  clk_seconds;
   logic        clk_cycling;
   logic [4:0]  cfg_alarm_hour;
   logic [5:0]  cfg_alarm_minute;
   logic [7:0]  cfg_ticks_per_sec;
   logic [7:0]  cfg_blink_tick;
   logic [15:0] cfg_banner;

   panel_word_type panel_queue[$];
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned mismatches = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_asked = 0;
   int unsigned stall_seen = 0;
   int unsigned stall_left = 0;
   bit          req_on = 1'b0;

   seven_segment_clock_controller i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seg_digit0  (rsp_seg_digit0),
      .rsp_seg_digit1  (rsp_seg_digit1),
      .rsp_seg_digit2  (rsp_seg_digit2),
      .rsp_seg_digit3  (rsp_seg_digit3),
      .rsp_beep_pulse  (rsp_beep_pulse),
      .rsp_alarm_start (rsp_alarm_start),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // one step up, back to zero at the limit
   function automatic int step_wrap(input int v, input int lim);
      return (v + 1 >= lim) ? 0 : v + 1;
   endfunction

   // segment pattern of a decimal digit, blank for anything above nine
   function automatic logic [7:0] glyph(input int d);
      return (d < 10) ? DIGIT_GLYPHS[d * 8 +: 8] : 8'h00;
   endfunction

   // apply one word to the predicted clock and work out what the display shows
   function automatic panel_word_type advance_clock(input sscc_pkg::op_type op,
                                                    input sscc_pkg::key_type kc);
      panel_word_type w;
      w = '0;
      if (op == sscc_pkg::OP_TICK) begin
         clk_ticks = clk_ticks + 8'd1;
         if (clk_ticks >= cfg_ticks_per_sec) begin
            clk_ticks = '0;
            clk_phase = 5'(step_wrap(clk_phase, sscc_pkg::PHASE_STEPS));
            clk_seconds = 6'(step_wrap(clk_seconds, sscc_pkg::SECONDS_WRAP));
            if (clk_seconds == 0) begin
               clk_minutes = 6'(step_wrap(clk_minutes, sscc_pkg::MINUTES_WRAP));
               if (clk_minutes == 0)
                  clk_hours = 5'(step_wrap(clk_hours, sscc_pkg::HOURS_WRAP));
            end
            w.alarm = (clk_hours == cfg_alarm_hour && clk_minutes == cfg_alarm_minute
                       && clk_seconds == 0);
         end
      end else begin
         w.beep = 1'b1;
         case (kc)
            sscc_pkg::KEY_HOUR_UP:
               clk_hours = 5'(step_wrap(clk_hours, sscc_pkg::HOURS_WRAP));
            sscc_pkg::KEY_MINUTE_UP:
               clk_minutes = 6'(step_wrap(clk_minutes, sscc_pkg::MINUTES_WRAP));
            sscc_pkg::KEY_SECOND_UP:
               clk_seconds = 6'(step_wrap(clk_seconds, sscc_pkg::SECONDS_WRAP));
            default:
               clk_cycling = ~clk_cycling;
         endcase
      end

      // mm.ss with blinking point, hh mm, or the banner
      if (!clk_cycling || clk_phase <= sscc_pkg::PHASE_LAST_MMSS) begin
         w.digit0 = glyph(clk_minutes / 10);
         w.digit1 = glyph(clk_minutes % 10);
         if (clk_ticks < cfg_blink_tick)
            w.digit1 = w.digit1 | sscc_pkg::POINT_BIT;
         w.digit2 = glyph(clk_seconds / 10);
         w.digit3 = glyph(clk_seconds % 10);
      end else if (clk_phase <= sscc_pkg::PHASE_LAST_HHMM) begin
         w.digit0 = glyph(clk_hours / 10);
         w.digit1 = glyph(clk_hours % 10);
         w.digit2 = glyph(clk_minutes / 10);
         w.digit3 = glyph(clk_minutes % 10);
      end else begin
         w.digit0 = glyph(cfg_banner[15:12]);
         w.digit1 = glyph(cfg_banner[11:8]);
         w.digit2 = glyph(cfg_banner[7:4]);
         w.digit3 = glyph(cfg_banner[3:0]);
      end
      return w;
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   // predict on every accepted word and register write, check every result word
   always @(posedge clock) begin : scoreboard
      panel_word_type want;
      if (reset) begin
         cfg_alarm_hour = sscc_pkg::ALARM_HOUR_RST;
         cfg_alarm_minute = sscc_pkg::ALARM_MINUTE_RST;
         cfg_ticks_per_sec = sscc_pkg::TICKS_PER_SECOND_RST;
         cfg_blink_tick = sscc_pkg::BLINK_TICK_RST;
         cfg_banner = sscc_pkg::BANNER_DIGITS_RST;
         clk_ticks = '0;
         clk_phase = '0;
         clk_hours = '0;
         clk_minutes = '0;
         clk_seconds = '0;
         clk_cycling = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sscc_pkg::CSR_ALARM_HOUR:       cfg_alarm_hour = csr_wdata[4:0];
               sscc_pkg::CSR_ALARM_MINUTE:     cfg_alarm_minute = csr_wdata[5:0];
               sscc_pkg::CSR_TICKS_PER_SECOND: cfg_ticks_per_sec = csr_wdata[7:0];
               sscc_pkg::CSR_BLINK_TICK:       cfg_blink_tick = csr_wdata[7:0];
               sscc_pkg::CSR_BANNER_DIGITS:    cfg_banner = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            panel_queue.push_back(advance_clock(sscc_pkg::op_type'(req_operation),
                                                sscc_pkg::key_type'(req_key)));
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (panel_queue.size() == 0) begin
               mismatches++;
               $display("%0t ns: word expected none, got %h %h %h %h beep %b alarm %b",
                        $time, rsp_seg_digit0, rsp_seg_digit1, rsp_seg_digit2,
                        rsp_seg_digit3, rsp_beep_pulse, rsp_alarm_start);
            end else begin
               want = panel_queue.pop_front();
               compare_field("seg_digit0", want.digit0, rsp_seg_digit0);
               compare_field("seg_digit1", want.digit1, rsp_seg_digit1);
               compare_field("seg_digit2", want.digit2, rsp_seg_digit2);
               compare_field("seg_digit3", want.digit3, rsp_seg_digit3);
               compare_field("beep_pulse", want.beep, rsp_beep_pulse);
               compare_field("alarm_start", want.alarm, rsp_alarm_start);
            end
         end
      end
   end

   // result side: random stalls, or a long hold-off when the test asks for one
   always @(posedge clock) begin
      if (stall_asked != stall_seen) begin
         stall_seen <= stall_asked;
         stall_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic req_idle();
      if (req_on) begin
         req_valid <= 1'b0;
         req_on = 1'b0;
      end
   endtask

   // offer one word, valid held until it is taken
   task automatic send_word(input sscc_pkg::op_type op, input sscc_pkg::key_type kc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_idle();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key <= kc;
      req_on = 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_random_word();
      send_word(($urandom_range(3) == 0) ? sscc_pkg::OP_KEY : sscc_pkg::OP_TICK,
                sscc_pkg::key_type'($urandom_range(3)));
   endtask

   task automatic wait_drain();
      req_idle();
      while (words_checked < words_sent) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // rewrite every register once the block is idle, junk in the unused upper bits
   task automatic apply_settings(input int ah, input int am, input int tps, input int blink,
                                 input int banner);
      wait_drain();
      write_csr(sscc_pkg::CSR_ALARM_HOUR, {11'($urandom), 5'(ah)});
      write_csr(sscc_pkg::CSR_ALARM_MINUTE, {10'($urandom), 6'(am)});
      write_csr(sscc_pkg::CSR_TICKS_PER_SECOND, {8'($urandom), 8'(tps)});
      write_csr(sscc_pkg::CSR_BLINK_TICK, {8'($urandom), 8'(blink)});
      write_csr(sscc_pkg::CSR_BANNER_DIGITS, 16'(banner));
      // indexes past the last register must change nothing
      write_csr(sscc_pkg::CSR_BANNER_DIGITS + 3'($urandom_range(1, 3)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic int edge_or_any(input int hi);
      case ($urandom_range(3))
         0:       return 0;
         1:       return hi;
         default: return $urandom_range(hi);
      endcase
   endfunction

   // ticks still needed to end the second from a given count
   function automatic int ticks_to_second(input int count, input int thr);
      return (thr > count + 1) ? thr - count : 1;
   endfunction

   // reset values: hour, minute and second keys, point on then off, no second yet
   task automatic test_reset_state();
      send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_HOUR_UP);
      send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_MINUTE_UP);
      send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_SECOND_UP);
      repeat (8) send_word(sscc_pkg::OP_TICK, sscc_pkg::key_type'($urandom_range(3)));
      wait_drain();
   endtask

   task automatic test_settings_extremes();
      // threshold written below the running count, so the next tick ends the second
      apply_settings(int'(sscc_pkg::HOURS_WRAP) - 1, 63, 2, 0, 16'hfa9c);
      repeat (3) send_word(sscc_pkg::OP_TICK, sscc_pkg::KEY_MODE);
      // zero threshold makes every tick a second: walk all phases incl. banner blanks
      apply_settings(31, 0, 0, 255, 16'hfa9c);
      send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_MODE);
      repeat (int'(sscc_pkg::PHASE_STEPS)) send_word(sscc_pkg::OP_TICK, sscc_pkg::KEY_HOUR_UP);
      send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_MODE);
      wait_drain();
   endtask

   task automatic test_random_traffic(input int rounds);
      int tps;
      repeat (rounds) begin
         // short seconds mostly so time and phase move, now and then a slow one
         tps = ($urandom_range(3) == 0) ? edge_or_any(255) : $urandom_range(4);
         apply_settings(edge_or_any(31), edge_or_any(63), tps, edge_or_any(255),
                        edge_or_any(16'hffff));
         repeat ($urandom_range(30, 60)) send_random_word();
      end
   endtask

   // alarm set to the next minute boundary, seconds stepped part way, then ticked across
   task automatic test_alarm_approach();
      int tps, s0, c0, skip, th, tm, n;
      wait_drain();
      tps = $urandom_range(3);
      tm = (clk_minutes + 1) % int'(sscc_pkg::MINUTES_WRAP);
      th = (tm == 0) ? (clk_hours + 1) % int'(sscc_pkg::HOURS_WRAP) : clk_hours;
      apply_settings(th, tm, tps, edge_or_any(255), edge_or_any(16'hffff));
      s0 = clk_seconds;
      c0 = clk_ticks;
      skip = $urandom_range(int'(sscc_pkg::SECONDS_WRAP) - 1 - s0);
      repeat (skip) send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_SECOND_UP);
      n = ticks_to_second(c0, tps)
          + (int'(sscc_pkg::SECONDS_WRAP) - 1 - s0 - skip) * ticks_to_second(0, tps)
          + $urandom_range(3);
      repeat (n) send_word(sscc_pkg::OP_TICK, sscc_pkg::key_type'($urandom_range(3)));
   endtask

   // keys bring the time to 23:59:58, alarm at midnight, then tick through the wrap
   task automatic test_midnight_rollover();
      int tps, c0, nh, nm, ns, pick;
      wait_drain();
      tps = $urandom_range(2);
      apply_settings(0, 0, tps, edge_or_any(255), edge_or_any(16'hffff));
      c0 = clk_ticks;
      nh = int'(sscc_pkg::HOURS_WRAP) - 1 - clk_hours;
      nm = int'(sscc_pkg::MINUTES_WRAP) - 1 - clk_minutes;
      ns = (int'(sscc_pkg::SECONDS_WRAP) + 58 - clk_seconds) % int'(sscc_pkg::SECONDS_WRAP);
      while (nh + nm + ns != 0) begin
         pick = $urandom_range(nh + nm + ns - 1);
         if (pick < nh) begin
            send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_HOUR_UP);
            nh--;
         end else if (pick < nh + nm) begin
            send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_MINUTE_UP);
            nm--;
         end else begin
            send_word(sscc_pkg::OP_KEY, sscc_pkg::KEY_SECOND_UP);
            ns--;
         end
      end
      repeat (ticks_to_second(c0, tps) + ticks_to_second(0, tps) + $urandom_range(3))
         send_word(sscc_pkg::OP_TICK, sscc_pkg::key_type'($urandom_range(3)));
   endtask

   // result side held off while words keep coming, so the input stalls
   task automatic test_backpressure();
      wait_drain();
      stall_asked <= stall_asked + 1;
      repeat (40) send_random_word();
      wait_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_settings_extremes();
      // sender idles little and receiver much, then the reverse, then neither
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 11 : (p == 1) ? 85 : 0;
         recv_idle_pct = (p == 0) ? 85 : (p == 1) ? 11 : 0;
         test_random_traffic(4);
         repeat (2) test_alarm_approach();
         test_midnight_rollover();
      end
      test_backpressure();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && panel_queue.size() == 0) begin
         $display("seven_segment_clock_controller test passed");
      end else begin
         if (panel_queue.size() != 0)
            $display("%0t ns: %0d expected words never arrived", $time, panel_queue.size());
         $display("seven_segment_clock_controller test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("%0t ns: timeout", $time);
      $display("seven_segment_clock_controller test failed");
      $finish;
   end

endmodule
